// File: sv/wtp_pkg.sv
// Package with the shared types and constants of the WAH to PLWAH word compressor.
package wtp_pkg;

  localparam int unsigned WordW = 32;

  // Fields of a WAH/PLWAH code word.
  localparam int unsigned FillFlagBit = 31;
  localparam int unsigned PbFlagBit   = 29;
  localparam int unsigned PbOneBit    = 28;
  localparam int unsigned PbPosLsb    = 23;
  localparam int unsigned PbPosW      = 5;
  localparam int unsigned LitW        = 31;

  localparam logic [WordW-1:0] ZeroFillOne = 32'h8000_0001;
  localparam logic [WordW-1:0] ZeroLiteral = 32'h0000_0000;

  // Output queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [WordW-1:0] in_word;
    logic             end_of_vector;
  } wtp_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic             out_last;
  } wtp_out_t;

  // State of the one-word holding stage.
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
    logic             short_fill;
  } wtp_held_t;

  // What one input word produces: up to two results and the next held state.
  typedef struct packed {
    logic [1:0] num;
    wtp_out_t   res0;
    wtp_out_t   res1;
    wtp_held_t  held;
  } wtp_step_t;

endpackage

// File: sv/wah_to_plwah_word_compressor.sv
// Top level of the WAH to PLWAH word compressor.
//
// This block recodes a stream of 32-bit WAH code words into PLWAH code words,
// one word per cycle. A word accepted on the input channel lands in an input
// register; when the result queue has room for two results, it is recoded
// against the single held word and the results are written into the
// four-entry result queue, from which the output port reads them. Each
// word is held back until the next one arrives: a held zero literal then
// becomes the one-word zero fill, and a short fill followed by a literal with a
// single 0 or single 1 bit is merged with it into one word. The last word of a
// vector (end_of_vector set) flushes the held word, so such a word may produce
// two results, the final one carrying out_last. The input side sustains one
// transaction per cycle as long as the output side takes results as fast as
// they are produced; the single output port delivers one result per cycle, so
// a word that yields two results hands them out one after the other. The input stalls
// while the input register holds a word and the result queue holds more than
// two entries, because that word cannot be recoded until two results fit.
module wah_to_plwah_word_compressor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wtp_pkg::wtp_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wtp_pkg::wtp_out_t out_data_o
);
  import wtp_pkg::*;

  // Input register.
  logic      in_full_q, in_full_d;
  wtp_in_t   in_q;
  logic      in_accept;

  // Holding stage.
  wtp_held_t held_q;

  // Recoding and queue control.
  wtp_step_t step;
  logic      room;
  logic      proc;
  logic [1:0] wr_num;

  assign proc       = in_full_q && room;
  assign in_stall_o = in_full_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_full_d  = in_accept || (in_full_q && !proc);
  assign wr_num     = proc ? step.num : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // The held word and its flags only change when a word is recoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (proc) begin
      held_q <= step.held;
    end
  end

  wtp_recode u_recode (
    .held_i (held_q),
    .in_i   (in_q),
    .step_o (step)
  );

  wtp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_num_i    (wr_num),
    .wr_res0_i   (step.res0),
    .wr_res1_i   (step.res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The last word of a vector always leaves the holding stage empty.
  a_eov_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_q.end_of_vector) |=> !held_q.valid)
    else $error("held word survived end of vector");

  // A word flagged as a short fill really is a fill without piggyback bits.
  a_short_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q.valid && held_q.short_fill) |->
      (held_q.word[FillFlagBit] && (held_q.word[PbFlagBit:PbPosLsb] == '0)))
    else $error("short fill flag inconsistent with held word");

  // Every recoded word that is not held produces at least one result.
  a_result_or_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> ((step.num != 2'd0) || step.held.valid))
    else $error("recoded word vanished");

  // Two results come only from a flush at the end of a vector.
  a_two_on_eov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (step.num == 2'd2)) |-> (in_q.end_of_vector && held_q.valid))
    else $error("two results without a flush");

endmodule

// File: sv/wtp_recode.sv
// Combinational recoding of one WAH word against the held word.
module wtp_recode (
  input  wtp_pkg::wtp_held_t held_i,
  input  wtp_pkg::wtp_in_t   in_i,
  output wtp_pkg::wtp_step_t step_o
);
  import wtp_pkg::*;

  logic [LitW-1:0]   ones;
  logic [LitW-1:0]   zeros;
  logic              ones_single;
  logic              zeros_single;
  logic              is_pb;
  logic [LitW-1:0]   pos_vec;
  logic [PbPosW-1:0] pos;
  logic [WordW-1:0]  h_word;
  logic              h_short;
  logic [WordW-1:0]  merged;
  logic              new_short;

  assign ones         = in_i.in_word[LitW-1:0];
  assign zeros        = ~in_i.in_word[LitW-1:0];
  assign ones_single  = (ones != '0) && ((ones & (ones - 1'b1)) == '0);
  assign zeros_single = (zeros != '0) && ((zeros & (zeros - 1'b1)) == '0);
  assign is_pb        = !in_i.in_word[FillFlagBit] && (ones_single || zeros_single);
  assign pos_vec      = zeros_single ? zeros : ones;

  // The selected vector has a single set bit, so its position is an OR of indexes.
  always_comb begin
    pos = '0;
    for (int i = 0; i < LitW; i++) begin
      if (pos_vec[i]) begin
        pos = pos | PbPosW'(i);
      end
    end
  end

  // A held zero literal followed by another word becomes a one-word zero fill.
  assign h_word  = (held_i.word == ZeroLiteral) ? ZeroFillOne : held_i.word;
  assign h_short = (held_i.word == ZeroLiteral) ? 1'b1 : held_i.short_fill;

  always_comb begin
    merged = h_word;
    merged[PbFlagBit] = 1'b1;
    merged[PbOneBit]  = h_word[PbOneBit] | !zeros_single;
    merged[PbPosLsb +: PbPosW] = h_word[PbPosLsb +: PbPosW] | pos;
  end

  assign new_short = in_i.in_word[FillFlagBit] && (in_i.in_word[PbFlagBit:PbPosLsb] == '0);

  always_comb begin
    step_o = '0;
    if (!held_i.valid) begin
      if (in_i.end_of_vector) begin
        step_o.num  = 2'd1;
        step_o.res0 = '{out_word: in_i.in_word, out_last: 1'b1};
      end else begin
        step_o.held = '{valid: 1'b1, word: in_i.in_word, short_fill: new_short};
      end
    end else if (h_short && is_pb) begin
      step_o.num  = 2'd1;
      step_o.res0 = '{out_word: merged, out_last: in_i.end_of_vector};
    end else begin
      step_o.res0 = '{out_word: h_word, out_last: 1'b0};
      if (in_i.end_of_vector) begin
        step_o.num  = 2'd2;
        step_o.res1 = '{out_word: in_i.in_word, out_last: 1'b1};
      end else begin
        step_o.num  = 2'd1;
        step_o.held = '{valid: 1'b1, word: in_i.in_word, short_fill: new_short};
      end
    end
  end

endmodule

// File: sv/wtp_out_queue.sv
// Result queue that takes up to two results a cycle and delivers one.
module wtp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_num_i,
  input  wtp_pkg::wtp_out_t wr_res0_i,
  input  wtp_pkg::wtp_out_t wr_res1_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wtp_pkg::wtp_out_t out_data_o
);
  import wtp_pkg::*;

  wtp_out_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QPtrW-1:0] wr_ptr_nx;
  logic             rd_en;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign rd_en       = out_valid_o && !out_stall_i;
  // Room is judged on the current fill so that two results always fit.
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(wr_num_i);
    rd_ptr_d = rd_ptr_q + QPtrW'(rd_en);
    cnt_d    = cnt_q + QCntW'(wr_num_i) - QCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_res0_i;
    end
    if (wr_num_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= wr_res1_i;
    end
  end

  // The fill level never exceeds the queue depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // Writes only happen while there was room for two results.
  a_write_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_num_i != 2'd0) |-> room_o)
    else $error("result queue written without room");

endmodule
